@@ rtl/core/crff_pkg.sv @@
// Package with the types, codes and constants shared by the CAN receive filter FIFO.
package crff_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int FILTER_COUNT = 3;
	localparam int ID_W = 29;
	localparam int LEN_W = 4;
	localparam int DATA_W = 64;
	localparam int MATCH_W = 2;
	localparam int PEND_W = 4;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int NUM_FILTERS_REGS = 3;
	localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

	localparam logic ACT_RECEIVE = 1'b0;
	localparam logic ACT_POP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NO_MATCH = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_F0_ID     = 3'd0,
		REG_F0_MASK   = 3'd1,
		REG_F1_ID     = 3'd2,
		REG_F1_MASK   = 3'd3,
		REG_F2_ID     = 3'd4,
		REG_F2_MASK   = 3'd5,
		REG_ACTIVE    = 3'd6,
		REG_FILTER_ON = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   frame_id;
		logic [LEN_W-1:0]  frame_length;
		logic [DATA_W-1:0] frame_data;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    out_id;
		logic [LEN_W-1:0]   out_length;
		logic [DATA_W-1:0]  out_data;
		logic [MATCH_W-1:0] out_match;
		logic [PEND_W-1:0]  pending;
	} rsp_t;

	typedef struct packed {
		logic [NUM_FILTERS_REGS-1:0][ID_W-1:0] fid;
		logic [NUM_FILTERS_REGS-1:0][ID_W-1:0] fmask;
		logic [NUM_FILTERS_REGS-1:0]           active;
		logic                                  filter_on;
	} cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [LEN_W-1:0]   length;
		logic [DATA_W-1:0]  data;
		logic [MATCH_W-1:0] match;
	} entry_t;

endpackage

@@ rtl/core/crff_regs.sv @@
// Configuration register bank with its APB-style write and read port.
module crff_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crff_pkg::PADDR_W-1:0] paddr,
	input  logic [crff_pkg::PDATA_W-1:0] pwdata,
	output logic [crff_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output crff_pkg::cfg_t               cfg
);
	import crff_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{fid: '0, fmask: '0, active: '0, filter_on: 1'b1};
		end else if (wr_en) begin
			unique case (idx)
				REG_F0_ID:     cfg_q.fid[0] <= pwdata[ID_W-1:0];
				REG_F0_MASK:   cfg_q.fmask[0] <= pwdata[ID_W-1:0];
				REG_F1_ID:     cfg_q.fid[1] <= pwdata[ID_W-1:0];
				REG_F1_MASK:   cfg_q.fmask[1] <= pwdata[ID_W-1:0];
				REG_F2_ID:     cfg_q.fid[2] <= pwdata[ID_W-1:0];
				REG_F2_MASK:   cfg_q.fmask[2] <= pwdata[ID_W-1:0];
				REG_ACTIVE:    cfg_q.active <= pwdata[NUM_FILTERS_REGS-1:0];
				REG_FILTER_ON: cfg_q.filter_on <= pwdata[0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_F0_ID:     prdata = PDATA_W'(cfg_q.fid[0]);
			REG_F0_MASK:   prdata = PDATA_W'(cfg_q.fmask[0]);
			REG_F1_ID:     prdata = PDATA_W'(cfg_q.fid[1]);
			REG_F1_MASK:   prdata = PDATA_W'(cfg_q.fmask[1]);
			REG_F2_ID:     prdata = PDATA_W'(cfg_q.fid[2]);
			REG_F2_MASK:   prdata = PDATA_W'(cfg_q.fmask[2]);
			REG_ACTIVE:    prdata = PDATA_W'(cfg_q.active);
			REG_FILTER_ON: prdata = PDATA_W'(cfg_q.filter_on);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/crff_filter.sv @@
// Priority acceptance filter compare of a frame identifier.
module crff_filter (
	input  crff_pkg::cfg_t                cfg,
	input  logic [crff_pkg::ID_W-1:0]     frame_id,
	output logic                          hit,
	output logic [crff_pkg::MATCH_W-1:0]  match
);
	import crff_pkg::*;

	always_comb begin
		hit = 1'b0;
		match = '0;
		// Scanning downward lets the lowest-numbered matching filter win.
		for (int n = FILTER_COUNT - 1; n >= 0; n--) begin
			if (cfg.active[n] && (((frame_id ^ cfg.fid[n]) & cfg.fmask[n]) == '0)) begin
				hit = 1'b1;
				match = MATCH_W'(n);
			end
		end
		if (!cfg.filter_on) begin
			hit = 1'b1;
			match = '0;
		end
	end

endmodule

@@ rtl/core/can_rx_filter_fifo_core.sv @@
// Top level of the CAN receive acceptance filter and frame FIFO.
//
// Channel   Direction  Handshake             Moves
// req       in         req_valid/req_ready   one receive or pop command
// rsp       out        rsp_valid/rsp_ready   one result per command
// apb       in         psel/penable/pwrite   filter register writes and reads
//
// One transfer is accepted per cycle while the result is not stalled; a result is offered once
// its command has passed through the input register, and is held in the result register.
// The FIFO read data is registered together with the result.
// Reset clears the pointers, the frame count, the valid flags and the filter registers, but sets filter_on.
// A stalled result holds the result register and lets one more command wait
// in the input register.
module can_rx_filter_fifo_core #(
	parameter int QUEUE_DEPTH = crff_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crff_pkg::PADDR_W-1:0] paddr,
	input  logic [crff_pkg::PDATA_W-1:0] pwdata,
	output logic [crff_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  crff_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output crff_pkg::rsp_t               rsp
);
	import crff_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	cfg_t               cfg;
	logic               s1_valid_q;
	req_t               req_s1;
	logic               rsp_valid_q;
	logic               s2_adv;
	logic               fire_s1;
	logic               hit;
	logic [MATCH_W-1:0] match;
	logic [LEN_W-1:0]   len_clamp;
	logic [DATA_W-1:0]  data_keep;
	logic               is_pop;
	logic               full;
	logic               empty;
	logic               do_push;
	logic               do_pop;
	status_t            status_c;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	entry_t             mem [QUEUE_DEPTH];
	entry_t             rd_entry_s2;
	status_t            status_s2;
	logic [CNT_W-1:0]   pend_s2;
	logic               pop_ok_s2;

	crff_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crff_filter u_filter (
		.cfg      (cfg),
		.frame_id (req_s1.frame_id),
		.hit      (hit),
		.match    (match)
	);

	assign s2_adv = !rsp_valid_q || rsp_ready;
	assign fire_s1 = s1_valid_q && s2_adv;
	assign req_ready = !s1_valid_q || s2_adv;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_comb begin
		len_clamp = (req_s1.frame_length > MAX_LEN) ? MAX_LEN : req_s1.frame_length;
		for (int b = 0; b < DATA_W / 8; b++) begin
			data_keep[8*b +: 8] = (LEN_W'(b) < len_clamp) ? req_s1.frame_data[8*b +: 8] : 8'h00;
		end
	end

	assign is_pop = (req_s1.action == ACT_POP);
	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = fire_s1 && !is_pop && !full && hit;
	assign do_pop = fire_s1 && is_pop && !empty;

	always_comb begin
		status_c = ST_OK;
		if (is_pop) begin
			if (empty) begin
				status_c = ST_EMPTY;
			end
		end else if (full) begin
			status_c = ST_FULL;
		end else if (!hit) begin
			status_c = ST_NO_MATCH;
		end
	end

	always_comb begin
		cnt_next = count_q;
		if (do_push) begin
			cnt_next = count_q + 1'b1;
		end else if (do_pop) begin
			cnt_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			count_q <= cnt_next;
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= '{id: req_s1.frame_id, length: len_clamp,
				data: data_keep, match: match};
		end
		if (do_pop) begin
			rd_entry_s2 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s2_adv) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_c;
			pend_s2 <= cnt_next;
			pop_ok_s2 <= do_pop;
		end
	end

	always_comb begin
		rsp.status = status_s2;
		rsp.out_id = pop_ok_s2 ? rd_entry_s2.id : '0;
		rsp.out_length = pop_ok_s2 ? rd_entry_s2.length : '0;
		rsp.out_data = pop_ok_s2 ? rd_entry_s2.data : '0;
		rsp.out_match = pop_ok_s2 ? rd_entry_s2.match : '0;
		rsp.pending = PEND_W'(pend_s2);
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("frame count exceeds queue depth");

	a_full_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_s2 == ST_FULL) |-> pend_s2 == FULL_CNT)
		else $error("full drop reported with room in queue");

	a_empty_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_s2 == ST_EMPTY) |-> pend_s2 == '0 && !pop_ok_s2)
		else $error("empty pop reported with frames pending");
`endif

endmodule
